/* src/hbac_pkg.sv */
// Shared types, codes and helper functions of the block heap allocator.
// No dependencies; every other file imports this package.
`default_nettype none
package hbac_pkg;

   localparam int MAX_HEAP_BLOCKS_DEF = 16384;
   localparam int CACHE_ENTRIES_DEF   = 8;
   localparam int HEAP_BLOCKS_RESET   = 16384;
   localparam int CSR_WIDTH           = 15;
   localparam int PROD_WIDTH          = 48;
   localparam int SPAN_WIDTH          = 45;

   localparam logic [15:0] FREE_ELEMENT_SIZE = 16'd16;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_SIZE = 2'd1;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd2;

   typedef struct packed {
      logic        command;
      logic [31:0] request_capacity;
      logic [15:0] element_size;
      logic        raw_mark;
      logic [13:0] freed_block;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] data_block;
      logic [31:0] granted_capacity;
   } rsp_type;

   typedef struct packed {
      logic        used;
      logic        raw;
      logic [15:0] es;
      logic [31:0] cap;
   } hdr_type;

   typedef struct packed {
      logic take;
      logic inval;
      logic push;
   } cache_op_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_FREE_RD,
      S_FREE_MUL,
      S_FREE_WR,
      S_MRG_RD,
      S_MRG_MUL,
      S_MRG_CHK,
      S_MRG_RDN,
      S_MRG_NXT,
      S_MRG_WR,
      S_FREE_PUSH,
      S_ALC_MUL,
      S_ALC_NEED,
      S_ALC_SCAN,
      S_ALC_FIT,
      S_ALC_SPLIT,
      S_ALC_HDR,
      S_FINISH
   } state_type;

   // blocks covered by a byte count, rounded up
   function automatic logic [SPAN_WIDTH-1:0] ceil16(input logic [PROD_WIDTH-1:0] p);
      logic [PROD_WIDTH:0] t;
      t = {1'b0, p} + (PROD_WIDTH+1)'(15);
      return t[PROD_WIDTH:4];
   endfunction

   function automatic logic [31:0] sat32(input logic [PROD_WIDTH-1:0] v);
      return (v > PROD_WIDTH'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // extra elements that fit in one spare block: floor(16 / es)
   function automatic logic [4:0] spare_elems(input logic [15:0] es);
      logic [4:0] r;
      case (es) inside
         16'd1:           r = 5'd16;
         16'd2:           r = 5'd8;
         16'd3:           r = 5'd5;
         16'd4:           r = 5'd4;
         16'd5:           r = 5'd3;
         [16'd6:16'd8]:   r = 5'd2;
         [16'd9:16'd16]:  r = 5'd1;
         default:         r = 5'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/hbac_hdr_ram.sv */
// Header store: one-write, one-read memory with registered read data.
// Depends on hbac_pkg for the header type.
`default_nettype none
module hbac_hdr_ram #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire hbac_pkg::hdr_type wr_data,
   input  wire logic            rd_en,
   input  wire logic [AW-1:0]   rd_addr,
   output hbac_pkg::hdr_type    rd_data
);
   import hbac_pkg::*;

   hdr_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* src/hbac_cache.sv */
// Free-header cache: valid bits and header indexes, with take, invalidate-by-index
// and push-to-front. Depends on hbac_pkg.
`default_nettype none
module hbac_cache #(
   parameter int N  = 8,
   parameter int AW = 14,
   parameter int SW = (N > 1) ? $clog2(N) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rebuild,
   input  wire hbac_pkg::cache_op_type op,
   input  wire logic [SW-1:0]     take_slot,
   input  wire logic [AW-1:0]     inval_idx,
   input  wire logic [AW-1:0]     push_idx,
   input  wire logic [SW-1:0]     sel_slot,
   output logic                   sel_valid,
   output logic [AW-1:0]          sel_idx
);
   import hbac_pkg::*;

   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  valid_ff, valid_in;
   logic [AW-1:0] idx_ff [N];
   logic [AW-1:0] idx_in [N];
   logic [CW-1:0] rank [N];
   logic [CW-1:0] keep_n;
   logic [CW-1:0] base;

   assign sel_valid = valid_ff[sel_slot];
   assign sel_idx   = idx_ff[sel_slot];

   always_comb begin
      keep_n = CW'($countones(valid_ff));
      if (keep_n == CW'(N)) begin
         keep_n = CW'(N - 1);
      end
      base = CW'(N - 1) - keep_n;
      for (int i = 0; i < N; i++) begin
         rank[i] = CW'($countones(valid_ff & ((N'(1) << i) - N'(1))));
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int d = 0; d < N; d++) begin
         idx_in[d] = idx_ff[d];
      end
      if (op.take) begin
         valid_in[take_slot] = 1'b0;
      end else if (op.inval) begin
         for (int i = 0; i < N; i++) begin
            if (valid_ff[i] && idx_ff[i] == inval_idx) begin
               valid_in[i] = 1'b0;
            end
         end
      end else if (op.push) begin
         // pack survivors toward the last slot, oldest dropped when full
         for (int d = 0; d < N; d++) begin
            valid_in[d] = (CW'(d) >= base);
            if (CW'(d) == base) begin
               idx_in[d] = push_idx;
            end
            for (int i = 0; i < N; i++) begin
               if (valid_ff[i] && rank[i] < keep_n && CW'(d) == base + rank[i] + CW'(1)) begin
                  idx_in[d] = idx_ff[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || rebuild) begin
         valid_ff      <= N'(1) << (N - 1);
         idx_ff[N-1]   <= '0;
      end else begin
         valid_ff <= valid_in;
         for (int d = 0; d < N; d++) begin
            idx_ff[d] <= idx_in[d];
         end
      end
   end

endmodule
`default_nettype wire

/* src/hbac_seq.sv */
// Sequencer and datapath: one shared multiplier, header walk, coalescing, split,
// clearing pass and result register. Depends on hbac_pkg.
`default_nettype none
module hbac_seq #(
   parameter int MAXB = 16384,
   parameter int N    = 8,
   parameter int AW   = 14,
   parameter int HW   = 15,
   parameter int SLW  = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              restart,
   input  wire logic [HW-1:0]     heap_blocks,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire hbac_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hbac_pkg::rsp_type      rsp_data,
   output logic                   ram_wr_en,
   output logic [AW-1:0]          ram_wr_addr,
   output hbac_pkg::hdr_type      ram_wr_data,
   output logic                   ram_rd_en,
   output logic [AW-1:0]          ram_rd_addr,
   input  wire hbac_pkg::hdr_type ram_rd_data,
   output hbac_pkg::cache_op_type cache_op,
   output logic [SLW-1:0]         cache_slot,
   output logic [AW-1:0]          cache_inval_idx,
   output logic [AW-1:0]          cache_push_idx,
   input  wire logic              cache_sel_valid,
   input  wire logic [AW-1:0]     cache_sel_idx
);
   import hbac_pkg::*;

   localparam int XW  = SPAN_WIDTH + 1;
   localparam int FW  = (HW > 14) ? HW : 14;
   localparam int DW  = (AW + 1 > 14) ? AW + 1 : 14;
   localparam int SCW = $clog2(N + 1);

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [AW-1:0]          h_ff, h_in;
   logic [AW-1:0]          n_ff, n_in;
   logic [AW-1:0]          r_ff, r_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic [PROD_WIDTH-1:0]  prodf_ff, prodf_in;
   logic [SPAN_WIDTH-1:0]  span_ff, span_in;
   logic [SPAN_WIDTH-1:0]  need_ff, need_in;
   logic [SPAN_WIDTH-1:0]  diff_ff, diff_in;
   logic [SCW-1:0]         slot_ff, slot_in;
   logic [31:0]            cap_ff, cap_in;
   logic [1:0]             status_ff, status_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [31:0]            mul_a;
   logic [15:0]            mul_b;
   logic [SPAN_WIDTH-1:0]  span_w;
   logic [XW-1:0]          nx_w;
   logic [XW-1:0]          rx_w;
   logic [XW-1:0]          hb_x;
   logic [SPAN_WIDTH-1:0]  diff_w;
   logic [PROD_WIDTH:0]    sum_w;
   logic [XW-1:0]          newcap_w;
   logic [32:0]            capx_w;
   logic                   fb_ok;
   logic                   scan_end;
   logic                   grant;
   logic                   out_free;
   logic [DW-1:0]          dblk_w;
   state_type              done_state;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign cache_slot = slot_ff[SLW-1:0];
   assign cache_inval_idx = n_ff;

   // shared unit: one 32x16 multiplier, registered product
   always_comb begin
      mul_a = req_ff.request_capacity;
      mul_b = req_ff.element_size;
      if (state_ff == S_FREE_MUL || state_ff == S_MRG_MUL || state_ff == S_MRG_NXT) begin
         mul_a = ram_rd_data.cap;
         mul_b = ram_rd_data.es;
      end
      prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   always_comb begin
      span_w   = ceil16(prod_ff);
      hb_x     = XW'(heap_blocks);
      nx_w     = XW'(h_ff) + XW'(span_w) + XW'(1);
      rx_w     = XW'(h_ff) + XW'(need_ff) + XW'(1);
      diff_w   = span_ff - need_ff;
      sum_w    = {1'b0, prodf_ff} + {1'b0, prod_ff};
      newcap_w = XW'(sum_w[PROD_WIDTH:4]) + XW'(1);
      capx_w   = {1'b0, req_ff.request_capacity} +
                 ((diff_w == SPAN_WIDTH'(1)) ? 33'(spare_elems(req_ff.element_size)) : 33'd0);
      fb_ok    = (req_data.freed_block != 14'd0) &&
                 (FW'(req_data.freed_block - 14'd1) < FW'(heap_blocks));
      scan_end = (slot_ff == SCW'(N));
      out_free = !rsp_valid_ff || rsp_ready;
      grant    = (status_ff == STATUS_OK) && (req_ff.command == CMD_ALLOC);
      dblk_w   = DW'(h_ff) + DW'(1);
      done_state = (req_ff.command == CMD_FREE) ? S_FREE_PUSH : S_ALC_FIT;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:     if (clr_ff == AW'(MAXB - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_FREE) begin
                  state_in = fb_ok ? S_FREE_RD : S_FINISH;
               end else begin
                  state_in = (req_data.element_size == 16'd0) ? S_FINISH : S_ALC_MUL;
               end
            end
         end
         S_FREE_RD:   state_in = S_FREE_MUL;
         S_FREE_MUL:  state_in = S_FREE_WR;
         S_FREE_WR:   state_in = S_MRG_RD;
         S_MRG_RD:    state_in = S_MRG_MUL;
         S_MRG_MUL:   state_in = S_MRG_CHK;
         S_MRG_CHK:   state_in = (nx_w >= hb_x) ? done_state : S_MRG_RDN;
         S_MRG_RDN:   state_in = S_MRG_NXT;
         S_MRG_NXT:   state_in = ram_rd_data.used ? done_state : S_MRG_WR;
         S_MRG_WR:    state_in = S_MRG_RD;
         S_FREE_PUSH: state_in = S_FINISH;
         S_ALC_MUL:   state_in = S_ALC_NEED;
         S_ALC_NEED:  state_in = S_ALC_SCAN;
         S_ALC_SCAN: begin
            if (scan_end) begin
               state_in = S_FINISH;
            end else if (cache_sel_valid) begin
               state_in = S_MRG_RD;
            end
         end
         S_ALC_FIT: begin
            if (need_ff > span_ff) begin
               state_in = S_ALC_SCAN;
            end else if (diff_w > SPAN_WIDTH'(1) && rx_w < hb_x) begin
               state_in = S_ALC_SPLIT;
            end else begin
               state_in = S_ALC_HDR;
            end
         end
         S_ALC_SPLIT: state_in = S_ALC_HDR;
         S_ALC_HDR:   state_in = S_FINISH;
         S_FINISH:    if (out_free) state_in = S_IDLE;
         default:     state_in = S_CLEAR;
      endcase
      if (restart) begin
         state_in = S_CLEAR;
      end
   end

   // memory and cache controls
   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = h_ff;
      ram_wr_data  = '{used: 1'b0, raw: 1'b0, es: FREE_ELEMENT_SIZE, cap: 32'd0};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = h_ff;
      cache_op     = '0;
      cache_push_idx = h_ff;
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            if (clr_ff == '0) begin
               ram_wr_data.cap = 32'(heap_blocks) - 32'd1;
            end else begin
               ram_wr_data = '0;
            end
         end
         S_FREE_RD, S_MRG_RD: ram_rd_en = 1'b1;
         S_MRG_RDN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = n_ff;
         end
         S_FREE_WR: begin
            ram_wr_en       = 1'b1;
            ram_wr_data.cap = sat32(PROD_WIDTH'(span_w));
         end
         S_MRG_WR: begin
            ram_wr_en       = 1'b1;
            ram_wr_data.cap = sat32(PROD_WIDTH'(newcap_w));
            cache_op.inval  = 1'b1;
         end
         S_FREE_PUSH: cache_op.push = 1'b1;
         S_ALC_FIT:   cache_op.take = (need_ff <= span_ff);
         S_ALC_SPLIT: begin
            ram_wr_en       = 1'b1;
            ram_wr_addr     = r_ff;
            ram_wr_data.cap = sat32(PROD_WIDTH'(diff_ff - SPAN_WIDTH'(1)));
            cache_op.push   = 1'b1;
            cache_push_idx  = r_ff;
         end
         S_ALC_HDR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '{used: 1'b1, raw: req_ff.raw_mark,
                            es: req_ff.element_size, cap: cap_ff};
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      req_in       = req_ff;
      h_in         = h_ff;
      n_in         = n_ff;
      r_in         = r_ff;
      clr_in       = clr_ff;
      prodf_in     = prodf_ff;
      span_in      = span_ff;
      need_in      = need_ff;
      diff_in      = diff_ff;
      slot_in      = slot_ff;
      cap_in       = cap_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + AW'(1);
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               h_in      = AW'(req_data.freed_block - 14'd1);
               slot_in   = '0;
               status_in = (req_data.command == CMD_ALLOC && req_data.element_size == 16'd0)
                           ? STATUS_ZERO_SIZE : STATUS_OK;
            end
         end
         S_MRG_CHK: begin
            span_in  = span_w;
            prodf_in = prod_ff;
            n_in     = AW'(nx_w);
         end
         S_ALC_NEED: need_in = span_w;
         S_ALC_SCAN: begin
            if (scan_end) begin
               status_in = STATUS_NO_FIT;
            end else if (cache_sel_valid) begin
               h_in = cache_sel_idx;
            end else begin
               slot_in = slot_ff + SCW'(1);
            end
         end
         S_ALC_FIT: begin
            if (need_ff > span_ff) begin
               slot_in = slot_ff + SCW'(1);
            end else begin
               diff_in = diff_w;
               r_in    = AW'(rx_w);
               if (diff_w <= SPAN_WIDTH'(1)) begin
                  cap_in = capx_w[32] ? 32'hFFFF_FFFF : capx_w[31:0];
               end else begin
                  cap_in = req_ff.request_capacity;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.status           = status_ff;
               rsp_in.data_block       = grant ? dblk_w[13:0] : 14'd0;
               rsp_in.granted_capacity = grant ? cap_ff : 32'd0;
            end
         end
         default: ;
      endcase
      if (restart) begin
         clr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      h_ff      <= h_in;
      n_ff      <= n_in;
      r_ff      <= r_in;
      prod_ff   <= prod_in;
      prodf_ff  <= prodf_in;
      span_ff   <= span_in;
      need_ff   <= need_in;
      diff_ff   <= diff_in;
      slot_ff   <= slot_in;
      cap_ff    <= cap_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_FINISH) |-> !ram_wr_en)
      else $error("header write outside an operation");

   a_cache_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cache_op.take, cache_op.inval, cache_op.push}))
      else $error("more than one cache operation in a cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !restart) |=> state_ff != S_IDLE)
      else $error("accepted beat did not start an operation");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !rsp_valid_ff && !restart) |=> rsp_valid_ff)
      else $error("finished operation lost its result");

endmodule
`default_nettype wire

/* src/block_heap_allocator_core.sv */
// Block heap allocator top level; the header walk with one multiplier and one read port sets
// the time. A rejected or out-of-range beat skips to its result; a free rewrites its
// header, merges free neighbors up to a used header or the heap end and caches it; an
// alloc sizes the request, merges and checks each valid cache slot, then writes any split
// remainder and the header. A new request can be taken as the result appears. After
// reset or a heap size write a clearing pass rebuilds the headers; requests wait for it.
`default_nettype none
module block_heap_allocator_core #(
   parameter int MAX_HEAP_BLOCKS = hbac_pkg::MAX_HEAP_BLOCKS_DEF,
   parameter int CACHE_ENTRIES   = hbac_pkg::CACHE_ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire hbac_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output hbac_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [hbac_pkg::CSR_WIDTH-1:0] csr_wdata
);
   import hbac_pkg::*;

   localparam int AW  = $clog2(MAX_HEAP_BLOCKS);
   localparam int HW  = $clog2(MAX_HEAP_BLOCKS + 1);
   localparam int SLW = $clog2(CACHE_ENTRIES);
   localparam int CW  = (HW > CSR_WIDTH) ? HW : CSR_WIDTH;
   localparam int HEAP_RESET = (MAX_HEAP_BLOCKS > HEAP_BLOCKS_RESET) ?
                               HEAP_BLOCKS_RESET : MAX_HEAP_BLOCKS;

   logic [HW-1:0] heap_blocks_ff, heap_blocks_in;
   logic [CW-1:0] csr_ext;
   logic          csr_beat;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   hdr_type       ram_wr_data, ram_rd_data;
   cache_op_type  cache_op;
   logic [SLW-1:0] cache_slot;
   logic [AW-1:0] cache_inval_idx, cache_push_idx, cache_sel_idx;
   logic          cache_sel_valid;

   assign csr_ready = 1'b1;
   assign csr_beat  = csr_valid && csr_ready;

   // clamp the written size to 2..MAX_HEAP_BLOCKS
   always_comb begin
      csr_ext        = CW'(csr_wdata);
      heap_blocks_in = heap_blocks_ff;
      if (csr_beat) begin
         if (csr_ext < CW'(2)) begin
            heap_blocks_in = HW'(2);
         end else if (csr_ext > CW'(MAX_HEAP_BLOCKS)) begin
            heap_blocks_in = HW'(MAX_HEAP_BLOCKS);
         end else begin
            heap_blocks_in = HW'(csr_ext);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_blocks_ff <= HW'(HEAP_RESET);
      end else begin
         heap_blocks_ff <= heap_blocks_in;
      end
   end

   hbac_hdr_ram #(.DEPTH(MAX_HEAP_BLOCKS), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hbac_cache #(.N(CACHE_ENTRIES), .AW(AW), .SW(SLW)) u_cache (
      .clock     (clock),
      .reset     (reset),
      .rebuild   (csr_beat),
      .op        (cache_op),
      .take_slot (cache_slot),
      .inval_idx (cache_inval_idx),
      .push_idx  (cache_push_idx),
      .sel_slot  (cache_slot),
      .sel_valid (cache_sel_valid),
      .sel_idx   (cache_sel_idx)
   );

   hbac_seq #(
      .MAXB (MAX_HEAP_BLOCKS),
      .N    (CACHE_ENTRIES),
      .AW   (AW),
      .HW   (HW),
      .SLW  (SLW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .restart         (csr_beat),
      .heap_blocks     (heap_blocks_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .cache_op        (cache_op),
      .cache_slot      (cache_slot),
      .cache_inval_idx (cache_inval_idx),
      .cache_push_idx  (cache_push_idx),
      .cache_sel_valid (cache_sel_valid),
      .cache_sel_idx   (cache_sel_idx)
   );

endmodule
`default_nettype wire

/* test/block_heap_allocator_core_tb.sv */
// Self-checking testbench for block_heap_allocator_core: drives alloc/free beats, predicts
// every response with its own heap and free-cache model and compares field by field.
// Depends on hbac_pkg (payload types, command and status codes).
`timescale 1ns / 1ps
module block_heap_allocator_core_tb;
   import hbac_pkg::*;

   localparam int HEAP_MAX   = MAX_HEAP_BLOCKS_DEF;
   localparam int SLOTS      = CACHE_ENTRIES_DEF;
   localparam int CYCLE_CAP  = 2000000;

   class rsp_scoreboard;
      rsp_type pending[$];
      int errors = 0;
      int matched = 0;

      function void note(rsp_type e);
         pending.push_back(e);
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with none pending: %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         matched++;
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.data_block !== e.data_block) begin
            $display("%0t: data_block expected %0d actual %0d", $time, e.data_block,
                     a.data_block);
            errors++;
         end
         if (a.granted_capacity !== e.granted_capacity) begin
            $display("%0t: granted_capacity expected %0d actual %0d", $time,
                     e.granted_capacity, a.granted_capacity);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_WIDTH-1:0] csr_wdata;

   block_heap_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   rsp_scoreboard board;
   int unsigned cycles = 0;
   bit calm = 0;
   int sent = 0;

   // heap model
   hdr_type     hstore[HEAP_MAX];
   bit          slot_ok[SLOTS];
   int unsigned slot_hdr[SLOTS];
   int unsigned heap_size;
   int unsigned granted[$];

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned blocks_of(int unsigned h);
      longint unsigned bytes;
      bytes = longint'(hstore[h].cap) * longint'(hstore[h].es);
      return (bytes + 15) / 16;
   endfunction

   function automatic void mark_free(int unsigned h, longint unsigned c);
      hstore[h].used = 0;
      hstore[h].raw  = 0;
      hstore[h].es   = FREE_ELEMENT_SIZE;
      hstore[h].cap  = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
   endfunction

   function automatic void cache_insert(int unsigned h);
      int unsigned keep[SLOTS];
      int n, base;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_ok[i]) begin
            keep[n] = slot_hdr[i];
            n++;
         end
      if (n == SLOTS) n--;
      for (int i = 0; i < SLOTS; i++) slot_ok[i] = 0;
      base = SLOTS - 1 - n;
      slot_ok[base] = 1;
      slot_hdr[base] = h;
      for (int i = 0; i < n; i++) begin
         slot_ok[base + 1 + i] = 1;
         slot_hdr[base + 1 + i] = keep[i];
      end
   endfunction

   function automatic void coalesce(int unsigned f);
      longint unsigned nx, sum;
      forever begin
         nx = longint'(f) + blocks_of(f) + 1;
         if (nx >= heap_size) break;
         if (hstore[nx].used) break;
         sum = longint'(hstore[f].es) * hstore[f].cap +
               longint'(hstore[nx].es) * hstore[nx].cap;
         mark_free(f, sum / 16 + 1);
         for (int i = 0; i < SLOTS; i++)
            if (slot_ok[i] && slot_hdr[i] == nx) slot_ok[i] = 0;
      end
   endfunction

   function automatic void heap_rebuild(int unsigned v);
      if (v < 2) v = 2;
      if (v > HEAP_MAX) v = HEAP_MAX;
      heap_size = v;
      for (int i = 0; i < HEAP_MAX; i++) hstore[i] = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_ok[i] = 0;
         slot_hdr[i] = 0;
      end
      mark_free(0, longint'(heap_size) - 1);
      slot_ok[SLOTS-1] = 1;
      granted.delete();
   endfunction

   function automatic rsp_type heap_answer(req_type r);
      rsp_type o;
      longint unsigned cap, have, need, rem;
      int unsigned h;
      o = '0;
      if (r.command == CMD_FREE) begin
         if (r.freed_block != 0 && r.freed_block - 1 < heap_size) begin
            h = r.freed_block - 1;
            mark_free(h, blocks_of(h));
            coalesce(h);
            cache_insert(h);
         end
         return o;
      end
      if (r.element_size == 0) begin
         o.status = STATUS_ZERO_SIZE;
         return o;
      end
      cap = r.request_capacity;
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_ok[i]) continue;
         h = slot_hdr[i];
         coalesce(h);
         have = blocks_of(h);
         need = (cap * r.element_size + 15) / 16;
         if (need > have) continue;
         slot_ok[i] = 0;
         if (have - need <= 1) begin
            cap += (have - need) * 16 / r.element_size;
            if (cap > 64'hFFFF_FFFF) cap = 64'hFFFF_FFFF;
         end else begin
            rem = longint'(h) + need + 1;
            if (rem < heap_size) begin
               mark_free(rem, have - need - 1);
               cache_insert(rem);
            end
         end
         hstore[h].used = 1;
         hstore[h].raw  = r.raw_mark;
         hstore[h].es   = r.element_size;
         hstore[h].cap  = cap[31:0];
         o.status = STATUS_OK;
         o.data_block = 14'(h + 1);
         o.granted_capacity = cap[31:0];
         granted.push_back(h + 1);
         return o;
      end
      o.status = STATUS_NO_FIT;
      return o;
   endfunction

   // runs right after a rising edge; leaves valid high, caller lowers or reloads it
   task automatic send_beat(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.note(heap_answer(r));
      sent++;
   endtask

   task automatic send_item(req_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      send_beat(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_heap_size(logic [CSR_WIDTH-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      heap_rebuild(v);
   endtask

   function automatic req_type alloc_of(logic [31:0] cap, logic [15:0] es, logic raw);
      req_type r;
      r = '0;
      r.command = CMD_ALLOC;
      r.request_capacity = cap;
      r.element_size = es;
      r.raw_mark = raw;
      r.freed_block = 14'($urandom);
      return r;
   endfunction

   function automatic req_type free_of(logic [13:0] fb);
      req_type r;
      r = req_type'({$urandom, $urandom});
      r.command = CMD_FREE;
      r.freed_block = fb;
      return r;
   endfunction

   function automatic req_type random_item();
      int pick, k;
      logic [15:0] es;
      pick = $urandom_range(0, 99);
      if (pick < 10) return req_type'({$urandom, $urandom, $urandom});
      if (pick < 15) return free_of(14'($urandom_range(0, heap_size + 2)));
      if (pick < 45 && granted.size() != 0) begin
         k = $urandom_range(0, granted.size() - 1);
         pick = granted[k];
         granted.delete(k);
         return free_of(14'(pick));
      end
      es = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
      if ($urandom_range(0, 30) == 0) es = 16'd0;
      return alloc_of($urandom_range(0, 48 * 16) / (es == 0 ? 1 : es) +
                      $urandom_range(0, 2), es, 1'($urandom));
   endfunction

   task automatic random_phase(int n);
      repeat (n) send_item(random_item());
   endtask

   // response side: random stalls, one long hold-off while requests keep coming
   initial begin
      int stall, taken;
      bit held;
      stall = 0;
      taken = 0;
      held = 0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            board.check(rsp_data);
            taken++;
         end
         if (!held && taken == 40) begin
            held = 1;
            stall = 600;
         end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0)
            stall = $urandom_range(1, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else
            rsp_ready <= 1'b1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      heap_rebuild(HEAP_BLOCKS_RESET);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, rejects, out-of-range and wrong frees
      send_item(alloc_of(32'd5, 16'd0, 1'b1));
      send_item(alloc_of(32'hFFFF_FFFF, 16'hFFFF, 1'b1));
      send_item(alloc_of(32'd0, 16'd1, 1'b0));
      send_item(alloc_of(32'd16, 16'd1, 1'b1));
      send_item(alloc_of(32'd1, 16'hFFFF, 1'b0));
      send_item(free_of(14'd0));
      send_item(free_of(14'h3FFF));
      send_item(free_of(14'd1));
      send_item(free_of(14'd3));
      send_item(free_of(14'd2));
      send_item(alloc_of(32'd3, 16'd5, 1'b1));
      send_item(alloc_of(32'd16382 * 16, 16'd1, 1'b0));
      random_phase(80);

      write_heap_size(15'd0);
      send_item(alloc_of(32'd0, 16'd16, 1'b1));
      send_item(alloc_of(32'd1, 16'd1, 1'b0));
      send_item(free_of(14'd1));
      send_item(free_of(14'd2));
      random_phase(30);

      write_heap_size(15'd64);
      random_phase(160);
      write_heap_size(15'd3);
      random_phase(40);
      write_heap_size(15'h7FFF);
      send_item(alloc_of(32'd16382, 16'd16, 1'b1));
      send_item(alloc_of(32'd0, 16'd1, 1'b1));
      send_item(free_of(14'd0));
      send_item(free_of(14'd16383));
      random_phase(60);
      write_heap_size(15'd200);
      random_phase(140);
      write_heap_size(15'd1000);
      calm = 1;
      random_phase(120);

      drain();
      $display("Ran %0d request beats over heap sizes 2 through 16384 with %0d responses",
               sent, board.matched);
      $display("checked, including stalls, a long response hold-off and idle gaps.");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
